// ----- sv/rpy_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpy_pkg
// Shared types, constants and the microcode table of the RPY mobility block.
// ----------------------------------------------------------------------------
package rpy_pkg;

	localparam int NUM_SPHERES = 3;
	localparam int IDX_W       = 2;
	localparam int PC_W        = 7;
	localparam int MAG_W       = 36;

	localparam logic [63:0] TWO_Q16    = 64'h20000;
	localparam logic [63:0] C_INV8PI   = 64'd170891319;
	localparam logic [63:0] C_INV16PI  = 64'd85445659;
	localparam logic [63:0] C_3INV16PI = 64'd256336978;
	localparam logic [63:0] C_THIRD    = 64'hAAAAAAAB;
	localparam logic [63:0] C_P32      = 64'h1_0000_0000;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
		logic signed [31:0] torque_x;
		logic signed [31:0] torque_y;
		logic signed [31:0] torque_z;
	} sphere_t;

	typedef enum logic [1:0] {OP_MUL, OP_SQRT, OP_DIV, OP_OUT} op_kind_t;
	typedef enum logic [1:0] {MD_LOAD, MD_ADD, MD_SUB} mode_t;
	typedef enum logic [1:0] {SQ_NEXT, SQ_NEAR, SQ_PEND, SQ_TEND} seq_t;

	typedef struct packed {
		op_kind_t    kind;
		mode_t       mode;
		logic [5:0]  a;
		logic [5:0]  b;
		logic [5:0]  sh;
		logic        wr;
		logic [5:0]  dst;
		seq_t        seq;
	} uop_t;

	typedef struct packed {
		uop_t             uop;
		logic             load;
		logic             opnd;
		logic             wb;
		logic [IDX_W-1:0] t;
		logic [IDX_W-1:0] s;
	} cmd_t;

	typedef struct packed {
		logic iter_done;
		logic near;
	} stat_t;

	// register file slots
	localparam logic [5:0] R_D0 = 6'd0, R_D1 = 6'd1, R_D2 = 6'd2, R_R2 = 6'd3;
	localparam logic [5:0] R_R = 6'd4, R_Q = 6'd5, R_Q2 = 6'd6, R_Q3 = 6'd7;
	localparam logic [5:0] R_E0 = 6'd8, R_E1 = 6'd9, R_E2 = 6'd10, R_K = 6'd11;
	localparam logic [5:0] R_TTID = 6'd12, R_TTRR = 6'd13, R_RT = 6'd14;
	localparam logic [5:0] R_RRID = 6'd15, R_RRRR = 6'd16, R_DF = 6'd17, R_DT = 6'd18;
	localparam logic [5:0] R_CF0 = 6'd19, R_CF1 = 6'd20, R_CF2 = 6'd21;
	localparam logic [5:0] R_CT0 = 6'd22, R_CT1 = 6'd23, R_CT2 = 6'd24;
	localparam logic [5:0] R_ACC0 = 6'd25, R_ACC1 = 6'd26, R_ACC2 = 6'd27;
	localparam logic [5:0] R_ACC3 = 6'd28, R_ACC4 = 6'd29, R_ACC5 = 6'd30;
	// slots reused once their first value is dead
	localparam logic [5:0] R_SO = R_D0, R_RO = R_D1, R_TQ2 = R_R2;

	// operand sources outside the register file
	localparam logic [5:0] O_PTX = 6'd32, O_PTY = 6'd33, O_PTZ = 6'd34;
	localparam logic [5:0] O_PSX = 6'd35, O_PSY = 6'd36, O_PSZ = 6'd37;
	localparam logic [5:0] O_FSX = 6'd38, O_FSY = 6'd39, O_FSZ = 6'd40;
	localparam logic [5:0] O_TSX = 6'd41, O_TSY = 6'd42, O_TSZ = 6'd43;
	localparam logic [5:0] O_ZERO = 6'd44, O_ONE = 6'd45, O_TWO = 6'd46;
	localparam logic [5:0] O_THIRD = 6'd47, O_P32 = 6'd48, O_C8 = 6'd49;
	localparam logic [5:0] O_C16 = 6'd50, O_C316 = 6'd51;

	// output slots for the copy-out ops
	localparam logic [5:0] OUT_VX = 6'd0, OUT_VY = 6'd1, OUT_VZ = 6'd2;
	localparam logic [5:0] OUT_WX = 6'd3, OUT_WY = 6'd4, OUT_WZ = 6'd5;

	localparam logic [PC_W-1:0] PC_TBEG = 7'd0;
	localparam logic [PC_W-1:0] PC_PAIR = 7'd6;
	localparam logic [PC_W-1:0] PC_TEND = 7'd77;

	function automatic uop_t mk(input op_kind_t kind, input mode_t mode,
			input logic [5:0] a, input logic [5:0] b, input logic [5:0] sh,
			input logic wr, input logic [5:0] dst, input seq_t seq);
		uop_t u;
		u.kind = kind; u.mode = mode; u.a = a; u.b = b; u.sh = sh;
		u.wr = wr; u.dst = dst; u.seq = seq;
		return u;
	endfunction

	// multiply op: T = a*b >> sh, or T +/- that; optional write of T
	function automatic uop_t mul(input logic [5:0] a, input logic [5:0] b,
			input logic [5:0] sh, input mode_t mode, input logic wr, input logic [5:0] dst);
		return mk(OP_MUL, mode, a, b, sh, wr, dst, SQ_NEXT);
	endfunction

	function automatic uop_t ucode(input logic [PC_W-1:0] pc);
		uop_t u;
		u = mul(O_ZERO, O_ONE, 6'd0, MD_LOAD, 1'b0, R_D0);
		case (pc)
			// clear the six accumulators for a new target
			7'd0:  u = mul(O_ZERO, O_ONE, 6'd0, MD_LOAD, 1'b1, R_ACC0);
			7'd1:  u = mul(O_ZERO, O_ONE, 6'd0, MD_LOAD, 1'b1, R_ACC1);
			7'd2:  u = mul(O_ZERO, O_ONE, 6'd0, MD_LOAD, 1'b1, R_ACC2);
			7'd3:  u = mul(O_ZERO, O_ONE, 6'd0, MD_LOAD, 1'b1, R_ACC3);
			7'd4:  u = mul(O_ZERO, O_ONE, 6'd0, MD_LOAD, 1'b1, R_ACC4);
			7'd5:  u = mul(O_ZERO, O_ONE, 6'd0, MD_LOAD, 1'b1, R_ACC5);
			// pair body: separation
			7'd6:  u = mul(O_PTX, O_ONE, 6'd0, MD_LOAD, 1'b0, R_D0);
			7'd7:  u = mul(O_PSX, O_ONE, 6'd0, MD_SUB, 1'b1, R_D0);
			7'd8:  u = mul(O_PTY, O_ONE, 6'd0, MD_LOAD, 1'b0, R_D1);
			7'd9:  u = mul(O_PSY, O_ONE, 6'd0, MD_SUB, 1'b1, R_D1);
			7'd10: u = mul(O_PTZ, O_ONE, 6'd0, MD_LOAD, 1'b0, R_D2);
			7'd11: u = mul(O_PSZ, O_ONE, 6'd0, MD_SUB, 1'b1, R_D2);
			7'd12: u = mul(R_D0, R_D0, 6'd16, MD_LOAD, 1'b0, R_R2);
			7'd13: u = mul(R_D1, R_D1, 6'd16, MD_ADD, 1'b0, R_R2);
			7'd14: u = mul(R_D2, R_D2, 6'd16, MD_ADD, 1'b1, R_R2);
			7'd15: u = mk(OP_SQRT, MD_LOAD, R_R2, O_ONE, 6'd0, 1'b1, R_R, SQ_NEAR);
			7'd16: u = mk(OP_DIV, MD_LOAD, R_R, O_ONE, 6'd0, 1'b1, R_Q, SQ_NEXT);
			7'd17: u = mul(R_Q, R_Q, 6'd32, MD_LOAD, 1'b1, R_Q2);
			7'd18: u = mul(R_Q2, R_Q, 6'd32, MD_LOAD, 1'b1, R_Q3);
			7'd19: u = mul(R_D0, R_Q, 6'd18, MD_LOAD, 1'b1, R_E0);
			7'd20: u = mul(R_D1, R_Q, 6'd18, MD_LOAD, 1'b1, R_E1);
			7'd21: u = mul(R_D2, R_Q, 6'd18, MD_LOAD, 1'b1, R_E2);
			// coefficients
			7'd22: u = mul(O_C8, R_Q, 6'd32, MD_LOAD, 1'b1, R_K);
			7'd23: u = mul(R_Q2, O_TWO, 6'd0, MD_LOAD, 1'b1, R_TQ2);
			7'd24: u = mul(R_TQ2, O_THIRD, 6'd33, MD_LOAD, 1'b0, R_TQ2);
			7'd25: u = mul(O_P32, O_ONE, 6'd0, MD_ADD, 1'b1, R_TQ2);
			7'd26: u = mul(R_K, R_TQ2, 6'd32, MD_LOAD, 1'b1, R_TTID);
			7'd27: u = mul(O_P32, O_ONE, 6'd0, MD_LOAD, 1'b0, R_TQ2);
			7'd28: u = mul(R_Q2, O_TWO, 6'd0, MD_SUB, 1'b1, R_TQ2);
			7'd29: u = mul(R_K, R_TQ2, 6'd32, MD_LOAD, 1'b1, R_TTRR);
			7'd30: u = mul(O_C8, R_Q2, 6'd32, MD_LOAD, 1'b1, R_RT);
			7'd31: u = mul(O_C16, R_Q3, 6'd32, MD_LOAD, 1'b1, R_RRID);
			7'd32: u = mul(O_C316, R_Q3, 6'd32, MD_LOAD, 1'b1, R_RRRR);
			// dot products
			7'd33: u = mul(R_E0, O_FSX, 6'd30, MD_LOAD, 1'b0, R_DF);
			7'd34: u = mul(R_E1, O_FSY, 6'd30, MD_ADD, 1'b0, R_DF);
			7'd35: u = mul(R_E2, O_FSZ, 6'd30, MD_ADD, 1'b1, R_DF);
			7'd36: u = mul(R_E0, O_TSX, 6'd30, MD_LOAD, 1'b0, R_DT);
			7'd37: u = mul(R_E1, O_TSY, 6'd30, MD_ADD, 1'b0, R_DT);
			7'd38: u = mul(R_E2, O_TSZ, 6'd30, MD_ADD, 1'b1, R_DT);
			// cross products
			7'd39: u = mul(O_FSY, R_E2, 6'd30, MD_LOAD, 1'b0, R_CF0);
			7'd40: u = mul(O_FSZ, R_E1, 6'd30, MD_SUB, 1'b1, R_CF0);
			7'd41: u = mul(O_FSZ, R_E0, 6'd30, MD_LOAD, 1'b0, R_CF1);
			7'd42: u = mul(O_FSX, R_E2, 6'd30, MD_SUB, 1'b1, R_CF1);
			7'd43: u = mul(O_FSX, R_E1, 6'd30, MD_LOAD, 1'b0, R_CF2);
			7'd44: u = mul(O_FSY, R_E0, 6'd30, MD_SUB, 1'b1, R_CF2);
			7'd45: u = mul(O_TSY, R_E2, 6'd30, MD_LOAD, 1'b0, R_CT0);
			7'd46: u = mul(O_TSZ, R_E1, 6'd30, MD_SUB, 1'b1, R_CT0);
			7'd47: u = mul(O_TSZ, R_E0, 6'd30, MD_LOAD, 1'b0, R_CT1);
			7'd48: u = mul(O_TSX, R_E2, 6'd30, MD_SUB, 1'b1, R_CT1);
			7'd49: u = mul(O_TSX, R_E1, 6'd30, MD_LOAD, 1'b0, R_CT2);
			7'd50: u = mul(O_TSY, R_E0, 6'd30, MD_SUB, 1'b1, R_CT2);
			7'd51: u = mul(R_TTRR, R_DF, 6'd32, MD_LOAD, 1'b1, R_SO);
			7'd52: u = mul(R_RRRR, R_DT, 6'd32, MD_LOAD, 1'b1, R_RO);
			// linear velocity
			7'd53: u = mul(R_TTID, O_FSX, 6'd32, MD_LOAD, 1'b0, R_ACC0);
			7'd54: u = mul(R_SO, R_E0, 6'd30, MD_ADD, 1'b0, R_ACC0);
			7'd55: u = mul(R_RT, R_CT0, 6'd32, MD_ADD, 1'b0, R_ACC0);
			7'd56: u = mul(R_ACC0, O_ONE, 6'd0, MD_ADD, 1'b1, R_ACC0);
			7'd57: u = mul(R_TTID, O_FSY, 6'd32, MD_LOAD, 1'b0, R_ACC1);
			7'd58: u = mul(R_SO, R_E1, 6'd30, MD_ADD, 1'b0, R_ACC1);
			7'd59: u = mul(R_RT, R_CT1, 6'd32, MD_ADD, 1'b0, R_ACC1);
			7'd60: u = mul(R_ACC1, O_ONE, 6'd0, MD_ADD, 1'b1, R_ACC1);
			7'd61: u = mul(R_TTID, O_FSZ, 6'd32, MD_LOAD, 1'b0, R_ACC2);
			7'd62: u = mul(R_SO, R_E2, 6'd30, MD_ADD, 1'b0, R_ACC2);
			7'd63: u = mul(R_RT, R_CT2, 6'd32, MD_ADD, 1'b0, R_ACC2);
			7'd64: u = mul(R_ACC2, O_ONE, 6'd0, MD_ADD, 1'b1, R_ACC2);
			// angular velocity
			7'd65: u = mul(R_RT, R_CF0, 6'd32, MD_LOAD, 1'b0, R_ACC3);
			7'd66: u = mul(R_RRID, O_TSX, 6'd32, MD_SUB, 1'b0, R_ACC3);
			7'd67: u = mul(R_RO, R_E0, 6'd30, MD_ADD, 1'b0, R_ACC3);
			7'd68: u = mul(R_ACC3, O_ONE, 6'd0, MD_ADD, 1'b1, R_ACC3);
			7'd69: u = mul(R_RT, R_CF1, 6'd32, MD_LOAD, 1'b0, R_ACC4);
			7'd70: u = mul(R_RRID, O_TSY, 6'd32, MD_SUB, 1'b0, R_ACC4);
			7'd71: u = mul(R_RO, R_E1, 6'd30, MD_ADD, 1'b0, R_ACC4);
			7'd72: u = mul(R_ACC4, O_ONE, 6'd0, MD_ADD, 1'b1, R_ACC4);
			7'd73: u = mul(R_RT, R_CF2, 6'd32, MD_LOAD, 1'b0, R_ACC5);
			7'd74: u = mul(R_RRID, O_TSZ, 6'd32, MD_SUB, 1'b0, R_ACC5);
			7'd75: u = mul(R_RO, R_E2, 6'd30, MD_ADD, 1'b0, R_ACC5);
			7'd76: u = mk(OP_MUL, MD_ADD, R_ACC5, O_ONE, 6'd0, 1'b1, R_ACC5, SQ_PEND);
			// copy out saturated results
			7'd77: u = mk(OP_OUT, MD_LOAD, R_ACC0, O_ONE, 6'd0, 1'b0, OUT_VX, SQ_NEXT);
			7'd78: u = mk(OP_OUT, MD_LOAD, R_ACC1, O_ONE, 6'd0, 1'b0, OUT_VY, SQ_NEXT);
			7'd79: u = mk(OP_OUT, MD_LOAD, R_ACC2, O_ONE, 6'd0, 1'b0, OUT_VZ, SQ_NEXT);
			7'd80: u = mk(OP_OUT, MD_LOAD, R_ACC3, O_ONE, 6'd0, 1'b0, OUT_WX, SQ_NEXT);
			7'd81: u = mk(OP_OUT, MD_LOAD, R_ACC4, O_ONE, 6'd0, 1'b0, OUT_WY, SQ_NEXT);
			7'd82: u = mk(OP_OUT, MD_LOAD, R_ACC5, O_ONE, 6'd0, 1'b0, OUT_WZ, SQ_TEND);
			default: u = mk(OP_MUL, MD_LOAD, O_ZERO, O_ONE, 6'd0, 1'b0, R_D0, SQ_TEND);
		endcase
		return u;
	endfunction

endpackage

// ----- sv/rpy_iter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpy_iter
// Bit-serial square root (33 steps) and reciprocal divide (49 steps).
// ----------------------------------------------------------------------------
module rpy_iter import rpy_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        is_div,
	input  logic [63:0] opnd,
	output logic        done,
	output logic [63:0] result
);

	logic        busy_q, div_q, done_q;
	logic [5:0]  cnt_q;
	logic [65:0] x_q;
	logic [48:0] root_q;
	logic [36:0] rem_q;
	logic [33:0] dvs_q;
	logic [36:0] rem_n, trial;

	always_comb begin
		if (div_q) begin
			rem_n = {rem_q[35:0], x_q[65]};
			trial = {3'b0, dvs_q};
		end else begin
			rem_n = {rem_q[34:0], x_q[65:64]};
			trial = {2'b0, root_q[32:0], 2'b01};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= is_div ? 6'd49 : 6'd33;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q  <= is_div;
			dvs_q  <= opnd[33:0];
			root_q <= '0;
			rem_q  <= '0;
			// divide: dividend 2^48 shifted in MSB first; root: radicand r2 * 2^16
			x_q    <= is_div ? {1'b1, 65'b0} : {opnd[49:0], 16'b0};
		end else if (busy_q) begin
			x_q <= div_q ? {x_q[64:0], 1'b0} : {x_q[63:0], 2'b0};
			if (rem_n >= trial) begin
				rem_q  <= rem_n - trial;
				root_q <= {root_q[47:0], 1'b1};
			end else begin
				rem_q  <= rem_n;
				root_q <= {root_q[47:0], 1'b0};
			end
		end
	end

	assign done   = done_q;
	assign result = {15'b0, root_q};

endmodule

// ----- sv/rpy_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpy_dp
// Datapath: sphere store, register file, shared multiplier, root/divide unit.
// ----------------------------------------------------------------------------
module rpy_dp import rpy_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic [IDX_W-1:0]   sphere_index,
	input  sphere_t            load_data,
	output stat_t              st,
	output logic signed [31:0] out_v [6]
);

	sphere_t            store_q [NUM_SPHERES];
	sphere_t            tgt_q, src_q;
	logic signed [63:0] rf_q [32];
	logic signed [63:0] ra_q, rb_q;
	logic signed [63:0] opa, opb, t_q, t_new, val;
	logic [2*MAG_W-1:0] prod_s1, shd;
	logic               neg_s1, near_q, it_done, it_start;
	logic [63:0]        it_res;
	logic signed [31:0] out_q [6];

	function automatic logic signed [63:0] pick(input logic [5:0] code,
			input logic signed [63:0] rf, input sphere_t tg, input sphere_t sr);
		logic signed [63:0] v;
		v = rf;
		case (code)
			O_PTX:   v = 64'(tg.pos_x);
			O_PTY:   v = 64'(tg.pos_y);
			O_PTZ:   v = 64'(tg.pos_z);
			O_PSX:   v = 64'(sr.pos_x);
			O_PSY:   v = 64'(sr.pos_y);
			O_PSZ:   v = 64'(sr.pos_z);
			O_FSX:   v = 64'(sr.force_x);
			O_FSY:   v = 64'(sr.force_y);
			O_FSZ:   v = 64'(sr.force_z);
			O_TSX:   v = 64'(sr.torque_x);
			O_TSY:   v = 64'(sr.torque_y);
			O_TSZ:   v = 64'(sr.torque_z);
			O_ZERO:  v = 64'sd0;
			O_ONE:   v = 64'sd1;
			O_TWO:   v = 64'sd2;
			O_THIRD: v = signed'(C_THIRD);
			O_P32:   v = signed'(C_P32);
			O_C8:    v = signed'(C_INV8PI);
			O_C16:   v = signed'(C_INV16PI);
			O_C316:  v = signed'(C_3INV16PI);
			default: v = rf;
		endcase
		return v;
	endfunction

	function automatic logic [MAG_W-1:0] mag(input logic signed [63:0] v);
		logic [63:0] n;
		n = v[63] ? 64'(-v) : 64'(v);
		return n[MAG_W-1:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	assign opa = pick(cmd.uop.a, ra_q, tgt_q, src_q);
	assign opb = pick(cmd.uop.b, rb_q, tgt_q, src_q);

	// sphere store, written by load items, two registered reads
	always_ff @(posedge clk) begin
		if (cmd.load && (32'(sphere_index) < NUM_SPHERES))
			store_q[sphere_index] <= load_data;
		tgt_q <= store_q[cmd.t];
		src_q <= store_q[cmd.s];
	end

	// shared multiplier on magnitudes, sign carried alongside
	always_ff @(posedge clk) begin
		if (cmd.opnd) begin
			prod_s1 <= mag(opa) * mag(opb);
			neg_s1  <= opa[63] ^ opb[63];
		end
	end

	always_comb begin
		shd = prod_s1 >> cmd.uop.sh;
		val = neg_s1 ? -signed'(shd[63:0]) : signed'(shd[63:0]);
		case (cmd.uop.mode)
			MD_LOAD: t_new = val;
			MD_ADD:  t_new = t_q + val;
			MD_SUB:  t_new = t_q - val;
			default: t_new = val;
		endcase
	end

	always_ff @(posedge clk) begin
		ra_q <= rf_q[cmd.uop.a[4:0]];
		rb_q <= rf_q[cmd.uop.b[4:0]];
		if (cmd.wb && cmd.uop.kind == OP_MUL) begin
			t_q <= t_new;
			if (cmd.uop.wr)
				rf_q[cmd.uop.dst[4:0]] <= t_new;
		end else if (it_done) begin
			rf_q[cmd.uop.dst[4:0]] <= signed'(it_res);
		end
		if (cmd.wb && cmd.uop.kind == OP_OUT)
			out_q[cmd.uop.dst[2:0]] <= sat32(val);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			near_q <= 1'b0;
		else if (it_done && cmd.uop.kind == OP_SQRT)
			near_q <= (it_res <= TWO_Q16);
	end

	assign it_start = cmd.opnd && (cmd.uop.kind == OP_SQRT || cmd.uop.kind == OP_DIV);

	rpy_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (it_start),
		.is_div (cmd.uop.kind == OP_DIV),
		.opnd   (opa),
		.done   (it_done),
		.result (it_res)
	);

	assign st.iter_done = it_done;
	assign st.near      = near_q;
	assign out_v        = out_q;

endmodule

// ----- sv/rpy_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpy_ctrl
// Sequencer: walks the microcode over targets and source spheres.
// ----------------------------------------------------------------------------
module rpy_ctrl import rpy_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             action,
	input  stat_t            st,
	output cmd_t             cmd,
	output logic             busy,
	output logic             result_valid,
	output logic [IDX_W-1:0] target_index,
	output logic             last_result
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_ISSUE = 6'b000010,
		S_OPND  = 6'b000100,
		S_ITER  = 6'b001000,
		S_WB    = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_SPHERES - 1);

	state_t           state_q;
	logic [PC_W-1:0]  pc_q;
	logic [IDX_W-1:0] t_q, s_q;
	uop_t             uop;
	logic             accept;

	assign uop    = ucode(pc_q);
	assign accept = start && (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= PC_TBEG;
			t_q     <= '0;
			s_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && action) begin
						t_q     <= '0;
						s_q     <= '0;
						pc_q    <= PC_TBEG;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: state_q <= S_OPND;
				S_OPND: begin
					if (uop.kind == OP_SQRT || uop.kind == OP_DIV)
						state_q <= S_ITER;
					else
						state_q <= S_WB;
				end
				S_ITER: begin
					if (st.iter_done)
						state_q <= S_WB;
				end
				S_WB: begin
					state_q <= S_ISSUE;
					case (uop.seq)
						SQ_NEXT: pc_q <= pc_q + 1'b1;
						SQ_TEND: state_q <= S_EMIT;
						SQ_NEAR, SQ_PEND: begin
							if (uop.seq == SQ_NEAR && !st.near) begin
								pc_q <= pc_q + 1'b1;
							end else if (s_q == LAST) begin
								pc_q <= PC_TEND;
							end else begin
								s_q  <= s_q + 1'b1;
								pc_q <= PC_PAIR;
							end
						end
						default: pc_q <= pc_q + 1'b1;
					endcase
				end
				S_EMIT: begin
					if (t_q == LAST) begin
						state_q <= S_IDLE;
					end else begin
						t_q     <= t_q + 1'b1;
						s_q     <= '0;
						pc_q    <= PC_TBEG;
						state_q <= S_ISSUE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.uop  = uop;
		cmd.load = accept && !action;
		cmd.opnd = (state_q == S_OPND);
		cmd.wb   = (state_q == S_WB);
		cmd.t    = t_q;
		cmd.s    = s_q;
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = (state_q == S_EMIT);
	assign target_index = t_q;
	assign last_result  = (state_q == S_EMIT) && (t_q == LAST);

endmodule

// ----- sv/rpy_mobility_accumulator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpy_mobility_accumulator_core
// Far-field RPY mobility: sums pairwise sphere velocities in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a clock edge with start high and busy low.
//   action 0 loads sphere sphere_index (position, force, torque) and busy
//   stays low. action 1 computes all velocities: busy rises and one result
//   per sphere follows in index order, each on the result ports for exactly
//   one cycle with result_valid high; last_result marks the final one.
//   The receiver cannot stall; results are simply presented.
//   Sequencing: every microcode op passes through the issue, operand and
//   write-back states; multiply ops use the shared multiplier, root and divide
//   ops wait in the iterate state. A far pair runs 71 ops with one root and one
//   divide, a near or self pair stops after the root, and each target adds the
//   clearing, the copy-out and the result state.
//   Reset clears the sequencer; the sphere store holds nothing valid until
//   every slot has been loaded.
// ----------------------------------------------------------------------------
module rpy_mobility_accumulator_core import rpy_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               action,
	input  logic [1:0]         sphere_index,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] force_x,
	input  logic signed [31:0] force_y,
	input  logic signed [31:0] force_z,
	input  logic signed [31:0] torque_x,
	input  logic signed [31:0] torque_y,
	input  logic signed [31:0] torque_z,
	output logic               result_valid,
	output logic [1:0]         target_index,
	output logic signed [31:0] vel_x,
	output logic signed [31:0] vel_y,
	output logic signed [31:0] vel_z,
	output logic signed [31:0] spin_x,
	output logic signed [31:0] spin_y,
	output logic signed [31:0] spin_z,
	output logic               last_result
);

	cmd_t               cmd;
	stat_t              st;
	sphere_t            load_data;
	logic signed [31:0] out_v [6];

	always_comb begin
		load_data.pos_x    = pos_x;
		load_data.pos_y    = pos_y;
		load_data.pos_z    = pos_z;
		load_data.force_x  = force_x;
		load_data.force_y  = force_y;
		load_data.force_z  = force_z;
		load_data.torque_x = torque_x;
		load_data.torque_y = torque_y;
		load_data.torque_z = torque_z;
	end

	rpy_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.action       (action),
		.st           (st),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid),
		.target_index (target_index),
		.last_result  (last_result)
	);

	rpy_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sphere_index (sphere_index),
		.load_data    (load_data),
		.st           (st),
		.out_v        (out_v)
	);

	assign vel_x  = out_v[0];
	assign vel_y  = out_v[1];
	assign vel_z  = out_v[2];
	assign spin_x = out_v[3];
	assign spin_y = out_v[4];
	assign spin_z = out_v[5];

endmodule

// ----- sv/rpy_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpy_chk
// Port-level checks on the command and result timing of the core.
// ----------------------------------------------------------------------------
module rpy_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       action,
	input logic       result_valid,
	input logic       last_result
);

	// results only come out of a compute in progress
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result outside a compute");

	// the final result ends the compute
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_result |=> !busy)
		else $error("busy after last result");

	// results are never back to back
	a_res_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	// a compute starts only from an accepted compute item
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && action))
		else $error("busy without a compute item");

endmodule

bind rpy_mobility_accumulator_core rpy_chk u_chk (.*);
